[hdl/c3if_pkg.sv]
// Shared constants, register codes and pipeline types of the 3x3 image filter.
package c3if_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int PIXEL_BITS_DEFAULT = 16;

    localparam int CHANNELS        = 3;
    localparam int COLOR_W         = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int WIDTH_REG_W     = 13;
    localparam int HEIGHT_REG_W    = 16;
    localparam int OUT_QUEUE_DEPTH = 8;

    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;
    localparam int MAX_COLOR_RESET = 255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MAX_COLOR    = 3'd2,
        REG_FILTER_MODE  = 3'd3,
        REG_COLOR_MODE   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        FILTER_BLUR      = 2'd0,
        FILTER_LAPLACIAN = 2'd1,
        FILTER_SHARPEN   = 2'd2
    } filter_mode_t;

    typedef enum logic {
        COLOR_GRAY = 1'b0,
        COLOR_RGB  = 1'b1
    } color_mode_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } tap_mask_t;

    typedef struct packed {
        logic valid;
        logic last;
    } out_ctrl_t;

    typedef struct packed {
        logic                                 last;
        logic [CHANNELS-1:0][COLOR_W-1:0]     color;
    } result_t;

endpackage

[hdl/c3if_line_store.sv]
// Two row stores of the filter with read-before-write and width-one forwarding.
module c3if_line_store #(
    parameter int DEPTH      = c3if_pkg::MAX_WIDTH_DEFAULT,
    parameter int PIXEL_BITS = c3if_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              req_valid,
    input  logic [$clog2(DEPTH)-1:0]                          req_addr,
    input  logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0]     req_pixel,
    output logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0]     above_data,
    output logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0]     two_above_data
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0] above_mem     [DEPTH];
    logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0] two_above_mem [DEPTH];

    logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0] above_q_reg;
    logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0] two_above_q_reg;
    logic [c3if_pkg::CHANNELS-1:0][PIXEL_BITS-1:0] fwd_data_reg;
    logic                                          fwd_reg;
    logic                                          wb_valid_reg;
    logic [ADDR_W-1:0]                             wb_addr_reg;

    always_ff @(posedge aclk) begin
        if (req_valid) begin
            above_q_reg         <= above_mem[req_addr];
            two_above_q_reg     <= two_above_mem[req_addr];
            above_mem[req_addr] <= req_pixel;
        end
        if (wb_valid_reg) begin
            two_above_mem[wb_addr_reg] <= above_q_reg;
        end
        fwd_data_reg <= above_q_reg;
        wb_addr_reg  <= req_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            wb_valid_reg <= req_valid;
            fwd_reg      <= req_valid && wb_valid_reg && (wb_addr_reg == req_addr);
        end
    end

    assign above_data     = above_q_reg;
    assign two_above_data = fwd_reg ? fwd_data_reg : two_above_q_reg;

endmodule

[hdl/c3if_lane.sv]
// One colour lane: masked 3x3 sums, blur division, Laplacian/sharpen and clamp.
module c3if_lane #(
    parameter int PIXEL_BITS = c3if_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic [8:0][PIXEL_BITS-1:0]           taps,
    input  c3if_pkg::tap_mask_t                  mask,
    input  logic                                 lane_on,
    input  logic [1:0]                           filter_mode,
    input  logic [c3if_pkg::COLOR_W-1:0]         max_color,
    output logic [c3if_pkg::COLOR_W-1:0]         value
);

    localparam int SUM4_W      = PIXEL_BITS + 2;
    localparam int SUM_W       = PIXEL_BITS + 4;
    localparam int BLUR_SHIFT  = PIXEL_BITS + 7;
    localparam int MUL_W       = PIXEL_BITS + 4;
    localparam int PROD_W      = SUM_W + MUL_W;
    localparam int VAL_W       = (SUM_W > c3if_pkg::COLOR_W) ? SUM_W : c3if_pkg::COLOR_W;
    localparam logic [MUL_W-1:0] BLUR_MUL =
        MUL_W'(((64'd1 << BLUR_SHIFT) + 64'd8) / 64'd9);

    logic [8:0][PIXEL_BITS-1:0]     t;
    logic [2:0]                     row_out;
    logic [2:0]                     col_out;
    logic                           lap_mode;
    logic                           sharpen;

    logic [SUM4_W-1:0]              edge_sum_reg;
    logic [SUM4_W-1:0]              corner_sum_reg;
    logic [PIXEL_BITS-1:0]          centre_reg;
    logic [SUM_W-1:0]               blur_sum_reg;
    logic signed [SUM_W-1:0]        lap_b_reg;
    logic [PROD_W-1:0]              prod;
    logic [PIXEL_BITS-1:0]          quot_reg;
    logic signed [SUM_W-1:0]        lap_c_reg;
    logic [PIXEL_BITS+2:0]          kc;
    logic [VAL_W-1:0]               cand;
    logic [c3if_pkg::COLOR_W-1:0]   value_next;
    logic [c3if_pkg::COLOR_W-1:0]   value_reg;

    assign lap_mode = (filter_mode == c3if_pkg::FILTER_LAPLACIAN) ||
                      (filter_mode == c3if_pkg::FILTER_SHARPEN);
    assign sharpen  = (filter_mode == c3if_pkg::FILTER_SHARPEN);

    always_comb begin
        row_out = {mask.bottom, 1'b0, mask.top};
        col_out = {mask.right, 1'b0, mask.left};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                t[r*3+c] = (row_out[r] || col_out[c]) ? '0 : taps[r*3+c];
            end
        end
    end

    always_comb begin
        kc = {centre_reg, 2'b00} + (sharpen ? (PIXEL_BITS+3)'(centre_reg) : '0);
    end

    assign prod = PROD_W'(blur_sum_reg) * PROD_W'(BLUR_MUL);

    always_comb begin
        if (lap_mode) begin
            cand = lap_c_reg[SUM_W-1] ? '0 : VAL_W'(lap_c_reg[SUM_W-2:0]);
        end else begin
            cand = VAL_W'(quot_reg);
        end
        if (!lane_on) begin
            value_next = '0;
        end else if (cand > VAL_W'(max_color)) begin
            value_next = max_color;
        end else begin
            value_next = cand[c3if_pkg::COLOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        edge_sum_reg   <= SUM4_W'(t[1]) + SUM4_W'(t[7]) + SUM4_W'(t[3]) + SUM4_W'(t[5]);
        corner_sum_reg <= SUM4_W'(t[0]) + SUM4_W'(t[2]) + SUM4_W'(t[6]) + SUM4_W'(t[8]);
        centre_reg     <= t[4];

        blur_sum_reg   <= SUM_W'(edge_sum_reg) + SUM_W'(corner_sum_reg) + SUM_W'(centre_reg);
        lap_b_reg      <= $signed(SUM_W'(kc)) - $signed(SUM_W'(edge_sum_reg));

        quot_reg       <= prod[BLUR_SHIFT +: PIXEL_BITS];
        lap_c_reg      <= lap_b_reg;

        value_reg      <= value_next;
    end

    assign value = value_reg;

endmodule

[hdl/c3if_out_queue.sv]
// Merge of the lane results into one word and the result queue before the output.
module c3if_out_queue #(
    parameter int DEPTH = c3if_pkg::OUT_QUEUE_DEPTH
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   push,
    input  logic [c3if_pkg::CHANNELS-1:0][c3if_pkg::COLOR_W-1:0]   push_color,
    input  logic                                                   push_last,
    output logic                                                   out_valid,
    input  logic                                                   out_ready,
    output c3if_pkg::result_t                                      out_word,
    output logic [$clog2(DEPTH+1)-1:0]                             level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH+1);

    c3if_pkg::result_t  queue_mem [DEPTH];
    c3if_pkg::result_t  push_word;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   level_next;
    logic               pop;

    assign push_word.color = push_color;
    assign push_word.last  = push_last;
    assign pop             = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign out_valid = (level_reg != '0);
    assign out_word  = queue_mem[rd_ptr_reg];
    assign level     = level_reg;

endmodule

[hdl/conv3x3_image_filter.sv]
// Top level of the streaming 3x3 image filter: geometry, line stores, window, lanes.
//
// Takes one word per clock while s_tready is high, pixels of a frame in raster
// order followed by image_width+1 flush words, and returns each pixel filtered
// by box blur, Laplacian or sharpen with zero outside the frame, clamped to
// 0..max_color. A result leaves once the word that completes its 3x3
// neighbourhood is taken, which is one row plus one pixel behind that pixel.
// The rate is set by the two row stores (MAX_WIDTH entries of three channels
// each), which take one read and one write per clock; the three colour lanes
// work side by side and an eight-word result queue decouples the output
// side, so the input keeps flowing while a result waits and the queue has
// room. The row stores need no clearing after reset. Writing image_width or
// image_height restarts the frame; configure only while the block is idle.
module conv3x3_image_filter #(
    parameter int MAX_WIDTH  = c3if_pkg::MAX_WIDTH_DEFAULT,
    parameter int PIXEL_BITS = c3if_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c3if_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [c3if_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // red_in, green_in, blue_in
    input  logic                                s_tuser,   // command

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // red_out, green_out, blue_out
    output logic                                m_tlast
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MW_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W      = (MW_BITS > c3if_pkg::WIDTH_REG_W) ? MW_BITS
                                                                  : c3if_pkg::WIDTH_REG_W;
    localparam int ROW_W      = c3if_pkg::HEIGHT_REG_W;
    localparam int IN_ROW_W   = c3if_pkg::HEIGHT_REG_W + 1;
    localparam int CH         = c3if_pkg::CHANNELS;
    localparam int CW         = c3if_pkg::COLOR_W;
    localparam int QDEPTH     = c3if_pkg::OUT_QUEUE_DEPTH;
    localparam int LVL_W      = $clog2(QDEPTH + 1);
    localparam int CREDIT_W   = LVL_W + 2;
    localparam int LANE_LAT   = 4;
    localparam int WLAST_RESET = ((c3if_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                      : c3if_pkg::WIDTH_RESET) - 1;

    // configuration
    logic [COL_W-1:0]       wlast_reg;
    logic [ROW_W-1:0]       hlast_reg;
    logic [CW-1:0]          max_color_reg;
    logic [1:0]             filter_mode_reg;
    logic                   color_mode_reg;
    logic                   cfg_wr;
    logic                   geom_wr;
    logic [CMP_W-1:0]       width_val;
    logic [COL_W-1:0]       wlast_new;
    logic [ROW_W-1:0]       hlast_new;

    // frame counters
    logic [COL_W-1:0]       in_col_reg,  in_col_next;
    logic [IN_ROW_W-1:0]    in_row_reg,  in_row_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic [ROW_W-1:0]       out_row_reg, out_row_next;

    logic                   accept;
    logic                   full;
    logic                   go;
    logic                   emit;
    c3if_pkg::tap_mask_t    mask_now;
    logic [CH-1:0][PIXEL_BITS-1:0] pixel_now;

    // pipeline
    logic                           s1_valid_reg;
    c3if_pkg::tap_mask_t            s1_mask_reg;
    logic [CH-1:0][PIXEL_BITS-1:0]  s1_px_reg;
    logic [CH-1:0][PIXEL_BITS-1:0]  above_data;
    logic [CH-1:0][PIXEL_BITS-1:0]  two_above_data;
    logic [CH-1:0][8:0][PIXEL_BITS-1:0] win_reg;
    logic                           s2_valid_reg;
    c3if_pkg::tap_mask_t            s2_mask_reg;
    c3if_pkg::out_ctrl_t            lane_ctrl_reg [LANE_LAT];
    logic [CH-1:0][CW-1:0]          lane_value;

    // output side
    logic                           res_push;
    c3if_pkg::result_t              out_word;
    logic [LVL_W-1:0]               queue_level;
    logic [LANE_LAT+1:0]            busy_vec;
    logic [CREDIT_W-1:0]            credit_used;

    // configuration port
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr && ((cfg_index == c3if_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index == c3if_pkg::REG_IMAGE_HEIGHT));

    always_comb begin
        width_val = CMP_W'(cfg_data[c3if_pkg::WIDTH_REG_W-1:0]);
        if (width_val == '0) begin
            wlast_new = '0;
        end else if (width_val > CMP_W'(MAX_WIDTH)) begin
            wlast_new = COL_W'(MAX_WIDTH - 1);
        end else begin
            wlast_new = COL_W'(width_val - 1'b1);
        end
        hlast_new = (cfg_data == '0) ? '0 : ROW_W'(cfg_data - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg       <= COL_W'(WLAST_RESET);
            hlast_reg       <= ROW_W'(c3if_pkg::HEIGHT_RESET - 1);
            max_color_reg   <= CW'(c3if_pkg::MAX_COLOR_RESET);
            filter_mode_reg <= c3if_pkg::FILTER_BLUR;
            color_mode_reg  <= c3if_pkg::COLOR_GRAY;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                c3if_pkg::REG_IMAGE_WIDTH:  wlast_reg       <= wlast_new;
                c3if_pkg::REG_IMAGE_HEIGHT: hlast_reg       <= hlast_new;
                c3if_pkg::REG_MAX_COLOR:    max_color_reg   <= cfg_data;
                c3if_pkg::REG_FILTER_MODE:  filter_mode_reg <= cfg_data[1:0];
                c3if_pkg::REG_COLOR_MODE:   color_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage: frame position, tap masks and pixel select
    assign accept = s_tvalid && s_tready;
    assign full   = in_row_reg > IN_ROW_W'(hlast_reg);
    assign go     = accept && !(s_tuser && !full);
    assign emit   = (in_row_reg > IN_ROW_W'(1)) ||
                    ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));

    always_comb begin
        mask_now.emit   = emit;
        mask_now.top    = (out_row_reg == '0);
        mask_now.bottom = (out_row_reg == hlast_reg);
        mask_now.left   = (out_col_reg == '0);
        mask_now.right  = (out_col_reg == wlast_reg);
        mask_now.last   = mask_now.bottom && mask_now.right;
    end

    always_comb begin
        pixel_now = '0;
        if (!s_tuser && !full) begin
            pixel_now[0] = s_tdata[0 +: PIXEL_BITS];
            if (color_mode_reg == c3if_pkg::COLOR_RGB) begin
                pixel_now[1] = s_tdata[CW +: PIXEL_BITS];
                pixel_now[2] = s_tdata[2*CW +: PIXEL_BITS];
            end
        end
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (geom_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (go) begin
            if (in_col_reg == wlast_reg) begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (emit) begin
                if (mask_now.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_reg == wlast_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    c3if_line_store #(
        .DEPTH      (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_store (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (go),
        .req_addr       (in_col_reg),
        .req_pixel      (pixel_now),
        .above_data     (above_data),
        .two_above_data (two_above_data)
    );

    // window: shift left, bring in the new column
    always_ff @(posedge aclk) begin
        s1_mask_reg <= mask_now;
        s1_px_reg   <= pixel_now;
        s2_mask_reg <= s1_mask_reg;
        if (s1_valid_reg) begin
            for (int c = 0; c < CH; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[c][r*3]   <= win_reg[c][r*3+1];
                    win_reg[c][r*3+1] <= win_reg[c][r*3+2];
                end
                win_reg[c][2] <= two_above_data[c];
                win_reg[c][5] <= above_data[c];
                win_reg[c][8] <= s1_px_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < LANE_LAT; i++) begin
                lane_ctrl_reg[i] <= '0;
            end
        end else begin
            s1_valid_reg           <= go;
            s2_valid_reg           <= s1_valid_reg && s1_mask_reg.emit;
            lane_ctrl_reg[0].valid <= s2_valid_reg;
            lane_ctrl_reg[0].last  <= s2_mask_reg.last;
            for (int i = 1; i < LANE_LAT; i++) begin
                lane_ctrl_reg[i] <= lane_ctrl_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g < CH; g++) begin : g_lane
        logic lane_on;
        if (g == 0) begin : g_first
            assign lane_on = 1'b1;
        end else begin : g_other
            assign lane_on = (color_mode_reg == c3if_pkg::COLOR_RGB);
        end

        c3if_lane #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_lane (
            .aclk        (aclk),
            .taps        (win_reg[g]),
            .mask        (s2_mask_reg),
            .lane_on     (lane_on),
            .filter_mode (filter_mode_reg),
            .max_color   (max_color_reg),
            .value       (lane_value[g])
        );
    end

    // result queue and input credit
    assign res_push = lane_ctrl_reg[LANE_LAT-1].valid;

    c3if_out_queue #(
        .DEPTH (QDEPTH)
    ) u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_push),
        .push_color (lane_value),
        .push_last  (lane_ctrl_reg[LANE_LAT-1].last),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (out_word),
        .level      (queue_level)
    );

    always_comb begin
        busy_vec[0] = s1_valid_reg;
        busy_vec[1] = s2_valid_reg;
        for (int i = 0; i < LANE_LAT; i++) begin
            busy_vec[i+2] = lane_ctrl_reg[i].valid;
        end
        credit_used = CREDIT_W'(queue_level) + CREDIT_W'($countones(busy_vec));
    end

    assign s_tready = (credit_used < CREDIT_W'(QDEPTH));
    assign m_tdata  = out_word.color;
    assign m_tlast  = out_word.last;

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (queue_level < LVL_W'(QDEPTH)))
        else $error("result queue written while full");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_col_reg <= wlast_reg) && (out_col_reg <= wlast_reg))
        else $error("column counter beyond row end");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_row_reg <= hlast_reg) && (in_row_reg <= IN_ROW_W'(hlast_reg) + 2'd2))
        else $error("row counter beyond frame end");

    a_drop_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser && !full) |=> !s1_valid_reg)
        else $error("early flush word entered the pipeline");

endmodule
